// ----- sv/nwcs_pkg.sv -----
// Shared types and constants for the normalized weighted criteria scorer.
package nwcs_pkg;
    localparam int NCRIT = 8;
    localparam int CW = 32;
    localparam int SW = 56;
    localparam logic [63:0] WEIGHTS_A_RESET = 64'h0333026603330333;
    localparam logic [63:0] WEIGHTS_B_RESET = 64'h000000CD019A019A;
    localparam logic [31:0] MIN_RANGE = 32'd65;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [7:0] LOWER_BETTER = 8'b1100_0111;
    localparam int QW = 17;
    localparam logic [1:0] REG_WA = 2'd0;
    localparam logic [1:0] REG_WB = 2'd1;
    localparam logic [1:0] REG_NE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_DIV, ST_MAC, ST_NEXT, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic div_step;
        logic mac;
        logic next;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last;
    } t_status;
endpackage

// ----- sv/nwcs_ctrl.sv -----
// Sequencer that steps the datapath through the eight criteria of one item.
module nwcs_ctrl import nwcs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_stall,
    output logic    o_valid,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_step = 1'b0;
                    n_state        = ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.mac = 1'b1;
                n_state   = ST_NEXT;
            end
            ST_NEXT: begin
                if (i_status.last) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = ST_LOAD;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- sv/nwcs_dp.sv -----
// Bounds, serial divider and multiply-accumulate datapath.
module nwcs_dp import nwcs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [NCRIT*CW-1:0]    i_raw,
    input  logic [63:0]            i_wa,
    input  logic [63:0]            i_wb,
    input  logic                   i_ne,
    output t_status                o_status,
    output logic [NCRIT*CW-1:0]    o_norm,
    output logic signed [SW-1:0]   o_score
);
    logic [CW-1:0] r_min [NCRIT];
    logic [CW-1:0] r_max [NCRIT];
    logic [CW-1:0] r_raw [NCRIT];
    logic [CW-1:0] r_norm [NCRIT];
    logic [2:0]    r_k;
    logic [CW-1:0] r_rng;
    logic [CW-1:0] r_diff;
    logic          r_use;
    logic [48:0]   r_rem;
    logic [QW-1:0] r_q;
    logic [4:0]    r_cnt;
    logic signed [SW-1:0] r_acc;

    logic [CW-1:0] cur, new_lo, new_hi;
    logic [CW-1:0] v;
    logic signed [33:0] adj;
    logic signed [15:0] w;
    logic signed [49:0] prod;
    logic [63:0]  wsel;

    assign cur    = r_raw[r_k];
    assign new_lo = (cur < r_min[r_k]) ? cur : r_min[r_k];
    assign new_hi = (cur > r_max[r_k]) ? cur : r_max[r_k];
    assign o_status.div_done = (r_cnt == 5'd17) || !r_use;
    assign o_status.last     = (r_k == 3'(NCRIT-1));
    assign wsel = r_k[2] ? i_wb : i_wa;
    assign w    = wsel[{r_k[1:0], 4'd0} +: 16];
    assign prod = adj * w;

    always_comb begin
        if (!r_use) begin
            v = cur;
        end else if (r_q > ONE_Q16) begin
            v = CW'(ONE_Q16);
        end else begin
            v = CW'(r_q);
        end
        if (LOWER_BETTER[r_k]) begin
            adj = 34'sd65536 - $signed({2'b00, v});
        end else begin
            adj = $signed({2'b00, v});
        end
    end

    // Restoring division of (diff << 16) by range, one quotient bit per cycle.
    logic [48:0] sh;
    logic        nb;
    always_comb begin
        nb = (r_cnt == 5'd0) ? r_diff[0] : 1'b0;
        sh = {r_rem[47:0], nb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCRIT; i++) begin
                r_min[i] <= '1;
                r_max[i] <= '0;
            end
            r_k <= '0;
        end else begin
            if (i_cmd.load) begin
                r_k <= '0;
            end
            if (i_cmd.start) begin
                r_min[r_k] <= new_lo;
                r_max[r_k] <= new_hi;
            end
            if (i_cmd.next) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < NCRIT; i++) begin
                r_raw[i] <= i_raw[i*CW +: CW];
            end
            r_acc <= '0;
        end
        if (i_cmd.start) begin
            r_rng  <= new_hi - new_lo;
            r_use  <= i_ne && ((new_hi - new_lo) > MIN_RANGE);
            r_rem  <= 49'(cur - new_lo) >> 1;
            r_diff <= cur - new_lo;
            r_q    <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            if (sh >= {17'd0, r_rng}) begin
                r_rem <= sh - {17'd0, r_rng};
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.mac) begin
            r_norm[r_k] <= v;
            r_acc <= r_acc + SW'(prod);
        end
    end

    always_comb begin
        for (int i = 0; i < NCRIT; i++) begin
            o_norm[i*CW +: CW] = r_norm[i];
        end
    end
    assign o_score = r_acc;
endmodule

// ----- sv/normalized_weighted_criteria_scorer.sv -----
// Top level of the normalized weighted criteria scorer.
//  Channel | Signals                      | Direction
//  in      | i_valid, o_stall, i_raw_*    | transfer in
//  out     | o_valid, i_stall, o_norm_*   | transfer out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data | write only
// From its input transfer to its result, an item passes per criterion through a load state,
// the divider state (17 quotient steps, then done), an accumulate state and an advance state,
// all criteria sharing the one serial divider. Without normalization no quotient step is taken.
// Reset is synchronous and restores the weights and bounds.
// The result is held while the output is stalled; no item is taken meanwhile.
module normalized_weighted_criteria_scorer import nwcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_raw_distance,
    input  logic [31:0] i_raw_time,
    input  logic [31:0] i_raw_energy,
    input  logic [31:0] i_raw_safety,
    input  logic [31:0] i_raw_comfort,
    input  logic [31:0] i_raw_reliability,
    input  logic [31:0] i_raw_environmental,
    input  logic [31:0] i_raw_monetary,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_norm_distance,
    output logic [31:0] o_norm_time,
    output logic [31:0] o_norm_energy,
    output logic [31:0] o_norm_safety,
    output logic [31:0] o_norm_comfort,
    output logic [31:0] o_norm_reliability,
    output logic [31:0] o_norm_environmental,
    output logic [31:0] o_norm_monetary,
    output logic signed [55:0] o_weighted_score,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    logic [63:0] r_wa, r_wb;
    logic        r_ne;
    t_cmd        cmd;
    t_status     st;
    logic [NCRIT*CW-1:0] norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa <= WEIGHTS_A_RESET;
            r_wb <= WEIGHTS_B_RESET;
            r_ne <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WA: r_wa <= i_cfg_data;
                REG_WB: r_wb <= i_cfg_data;
                REG_NE: r_ne <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    nwcs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_out_stall(i_stall), .i_status(st),
        .o_stall, .o_valid, .o_cmd(cmd)
    );

    nwcs_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_raw({i_raw_monetary, i_raw_environmental, i_raw_reliability, i_raw_comfort,
                i_raw_safety, i_raw_energy, i_raw_time, i_raw_distance}),
        .i_wa(r_wa), .i_wb(r_wb), .i_ne(r_ne),
        .o_status(st), .o_norm(norm), .o_score(o_weighted_score)
    );

    assign {o_norm_monetary, o_norm_environmental, o_norm_reliability, o_norm_comfort,
            o_norm_safety, o_norm_energy, o_norm_time, o_norm_distance} = norm;
endmodule

// ----- sv/nwcs_checker.sv -----
// Port-level checker for the scorer, bound to the top level.
module nwcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_norm_distance
);
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_norm_distance)))
        else $error("result changed under stall");
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && !o_valid))
        else $error("not busy after transfer");
endmodule

bind normalized_weighted_criteria_scorer nwcs_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_norm_distance
);
